/* design/stq_pkg.sv */
// sorted timer queue package: queue entry and cell command types, codes
// and default sizes; no dependencies
`default_nettype none

package stq_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_FIRED_DEF   = 32;
  localparam logic [31:0] MIN_PERIOD_RESET = 32'd100000;

  localparam int ID_W = 4;

  // input operation codes
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_COMPARE = 2'd1;
  localparam logic [1:0] KIND_FIRED   = 2'd2;
  localparam logic [1:0] KIND_SHORT   = 2'd3;

  // cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic            periodic;
    logic [31:0]     period;
    logic [63:0]     expiry;
  } entry_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] id;
    entry_t          ins;
  } cmd_t;

endpackage

`default_nettype wire

/* design/stq_cell.sv */
// one queue position of the sorted timer chain
// depends on stq_pkg
`default_nettype none

module stq_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire stq_pkg::cmd_t   cmd,
  input  wire stq_pkg::entry_t left_entry,
  input  wire stq_pkg::entry_t right_entry,
  input  wire logic            left_seen,
  input  wire logic            left_gt,
  output stq_pkg::entry_t      entry,
  output logic                 seen,
  output logic                 gt
);
  import stq_pkg::*;

  // match at or before this cell, and empty or later than the new expiry
  assign seen = left_seen | (entry.valid && entry.id == cmd.id);
  assign gt   = !entry.valid || (entry.expiry > cmd.ins.expiry);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_REMOVE: begin
          if (seen) entry <= right_entry;
        end
        OP_INSERT: begin
          if (gt) entry <= left_gt ? left_entry : cmd.ins;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/sorted_timer_queue.sv */
// sorted timer queue top level: sequencer, slot expiry table and cell chain
// depends on stq_pkg and stq_cell
//
// channel  dir  handshake               payload
// s_*      in   s_tvalid/s_tready       tuser func, tdata timer_id..now
// m_*      out  m_tvalid/m_tready       tuser kind, tdata fired_id, compare_time; tlast
// cfg_*    in   cfg_valid/cfg_ready     cfg_data min_period_ticks
//
// one item at a time; add passes ADD, SCHB, SCHC, EMIT; a too short period ADD, EMIT;
// delete DELA, DELB, EMIT; a bad slot or unused func EMIT; tick TICK, EMIT per fired
// timer plus SCHB, SCHC per periodic reschedule, then TICK, EMIT to close; then IDLE
// each result passes a single output register; a stalled output holds the sequencer
// rst clears the chain valid bits and slot expiry table and sets min period to MIN_PERIOD_RESET

`default_nettype none

module sorted_timer_queue #(
  parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF,
  parameter int MAX_FIRED   = stq_pkg::MAX_FIRED_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [103:0]  s_tdata,  // timer_id[3:0] periodic[4] duration[36:5] now[100:37]
  input  wire logic [1:0]    s_tuser,  // func
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [71:0]        m_tdata,  // fired_id[3:0] compare_time[67:4]
  output logic [1:0]         m_tuser,  // kind
  output logic               m_tlast,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [31:0]   cfg_data
);
  import stq_pkg::*;

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int FW = $clog2(MAX_FIRED + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_SCHB  = 3'd2;
  localparam logic [2:0] ST_SCHC  = 3'd3;
  localparam logic [2:0] ST_DELA  = 3'd4;
  localparam logic [2:0] ST_DELB  = 3'd5;
  localparam logic [2:0] ST_TICK  = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0]      state, ret;
  logic [ID_W-1:0] in_id;
  logic            in_per;
  logic [31:0]     in_dur;
  logic [63:0]     in_now;
  logic            in_tick;
  logic [31:0]     min_period;
  logic [FW-1:0]   fired;
  logic            was_head;

  logic [ID_W-1:0] cur_id;
  logic            cur_periodic;
  logic [31:0]     cur_per;
  logic [63:0]     old_exp, new_exp;

  logic [1:0]      p_kind, out_kind;
  logic [ID_W-1:0] p_id, out_id;
  logic [63:0]     p_cmp, out_cmp;
  logic            p_last, out_last;

  logic [63:0]     slot_expiry   [TIMER_SLOTS];

  cmd_t   cmd;
  entry_t cells [TIMER_SLOTS];
  logic   seen  [TIMER_SLOTS];
  logic   gt    [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] valid_vec;

  logic [SW-1:0] in_sidx, cur_sidx;
  logic          out_free, bad_id, too_short;
  logic [31:0]   add_period;
  logic          found;
  logic [63:0]   found_exp, base, sched_exp;

  assign in_sidx    = SW'(in_id);
  assign cur_sidx   = SW'(cur_id);
  assign out_free   = !m_tvalid || m_tready;
  assign bad_id     = 32'(in_id) >= 32'(TIMER_SLOTS);
  assign too_short  = in_per && (in_dur < min_period);
  assign add_period = (!in_per && in_dur == 32'd0) ? 32'd1 : in_dur;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'b0, out_cmp, out_id};
  assign m_tuser   = out_kind;
  assign m_tlast   = out_last;

  // cell chain
  genvar g;
  generate
    for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
      entry_t le, re;
      logic   ls, lg;
      if (g == 0) begin : g_first
        assign le = '0;
        assign ls = 1'b0;
        assign lg = 1'b0;
      end else begin : g_mid
        assign le = cells[g-1];
        assign ls = seen[g-1];
        assign lg = gt[g-1];
      end
      if (g == TIMER_SLOTS - 1) begin : g_last
        assign re = '0;
      end else begin : g_next
        assign re = cells[g+1];
      end
      stq_cell u_cell (
        .clk, .rst, .cmd,
        .left_entry(le), .right_entry(re), .left_seen(ls), .left_gt(lg),
        .entry(cells[g]), .seen(seen[g]), .gt(gt[g])
      );
      assign valid_vec[g] = cells[g].valid;
    end
  endgenerate

  // first queued periodic timer with the same period, and the expiry to schedule
  always_comb begin
    found     = 1'b0;
    found_exp = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (cells[i].valid && cells[i].periodic && cells[i].period == cur_per) begin
        found     = 1'b1;
        found_exp = cells[i].expiry;
      end
    end
    if (old_exp != 64'd0) base = old_exp;
    else if (found)       base = found_exp;
    else                  base = in_now;
    sched_exp = cur_periodic ? (base + 64'(cur_per)) : (in_now + 64'(cur_per));
  end

  // chain command
  always_comb begin
    cmd.op  = OP_HOLD;
    cmd.id  = in_id;
    cmd.ins = '{valid: 1'b1, id: cur_id, periodic: cur_periodic,
                period: cur_per, expiry: new_exp};
    unique case (state)
      ST_ADD:  if (!too_short) cmd.op = OP_REMOVE;
      ST_DELA: cmd.op = OP_REMOVE;
      ST_SCHC: cmd.op = OP_INSERT;
      ST_TICK: begin
        cmd.id = cells[0].id;
        if (cells[0].valid && cells[0].expiry <= in_now && 32'(fired) < 32'(MAX_FIRED))
          cmd.op = OP_REMOVE;
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) min_period <= MIN_PERIOD_RESET;
    else if (cfg_valid && cfg_ready) min_period <= cfg_data;
  end

  // slot expiry table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        slot_expiry[i] <= '0;
      end
    end else if (state == ST_SCHC) begin
      slot_expiry[cur_sidx] <= new_exp;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
      out_kind <= p_kind;
      out_id   <= p_id;
      out_cmp  <= p_cmp;
      out_last <= p_last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      fired <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_id   <= s_tdata[3:0];
            in_per  <= s_tdata[4];
            in_dur  <= s_tdata[36:5];
            in_now  <= s_tdata[100:37];
            in_tick <= (s_tuser == FUNC_TICK);
            fired   <= '0;
            p_id    <= '0;
            p_cmp   <= '0;
            p_last  <= 1'b1;
            p_kind  <= KIND_NONE;
            ret     <= ST_IDLE;
            priority if (s_tuser == FUNC_TICK)       state <= ST_TICK;
            else if (32'(s_tdata[3:0]) >= 32'(TIMER_SLOTS) || s_tuser == 2'd3)
                                                     state <= ST_EMIT;
            else if (s_tuser == FUNC_DELETE)         state <= ST_DELA;
            else                                     state <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (bad_id) begin
            state <= ST_EMIT;
          end else if (too_short) begin
            p_kind <= KIND_SHORT;
            state  <= ST_EMIT;
          end else begin
            cur_id       <= in_id;
            cur_periodic <= in_per;
            cur_per      <= add_period;
            old_exp      <= slot_expiry[in_sidx];
            state        <= ST_SCHB;
          end
        end
        ST_SCHB: begin
          new_exp <= sched_exp;
          state   <= ST_SCHC;
        end
        ST_SCHC: begin
          if (in_tick) begin
            state <= ST_TICK;
          end else begin
            p_kind <= gt[0] ? KIND_COMPARE : KIND_NONE;
            p_cmp  <= gt[0] ? new_exp : 64'd0;
            ret    <= ST_IDLE;
            state  <= ST_EMIT;
          end
        end
        ST_DELA: begin
          was_head <= cells[0].valid && cells[0].id == in_id;
          state    <= ST_DELB;
        end
        ST_DELB: begin
          if (was_head && cells[0].valid) begin
            p_kind <= KIND_COMPARE;
            p_cmp  <= cells[0].expiry;
          end
          state <= ST_EMIT;
        end
        ST_TICK: begin
          p_id   <= '0;
          p_cmp  <= '0;
          p_last <= 1'b1;
          ret    <= ST_IDLE;
          state  <= ST_EMIT;
          priority if (!cells[0].valid) begin
            p_kind <= KIND_NONE;
          end else if (cells[0].expiry > in_now) begin
            p_kind <= KIND_COMPARE;
            p_cmp  <= cells[0].expiry;
          end else if (32'(fired) >= 32'(MAX_FIRED)) begin
            p_kind <= KIND_COMPARE;
            p_cmp  <= in_now;
          end else begin
            p_kind       <= KIND_FIRED;
            p_id         <= cells[0].id;
            p_last       <= 1'b0;
            fired        <= fired + 1'b1;
            cur_id       <= cells[0].id;
            cur_periodic <= cells[0].periodic;
            cur_per      <= cells[0].period;
            old_exp      <= cells[0].expiry;
            ret          <= cells[0].periodic ? ST_SCHB : ST_TICK;
          end
        end
        ST_EMIT: begin
          if (out_free) state <= ret;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_fired_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fired) <= 32'(MAX_FIRED)) else $error("fired count beyond limit");

  a_chain_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0) else $error("chain has a hole");

  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_FIRED |-> !m_tlast) else $error("fired item marked last");

  a_idle_no_tick_insert: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCHC |-> $past(state) == ST_SCHB) else $error("insert without schedule");

endmodule

`default_nettype wire

/* dv/tb_sorted_timer_queue.sv */
// testbench for sorted_timer_queue: directed table then random phases, all
// results checked against an in-bench model of the expiry-ordered queue
// depends on stq_pkg and the sorted_timer_queue rtl
`default_nettype none

module tb_sorted_timer_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import stq_pkg::*;

  localparam int SLOTS = 16;
  localparam int FIRE_LIMIT = 32;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  fid;
    logic [63:0] cmp;
    logic        last;
  } timer_res_t;

  typedef struct {
    logic [1:0]  func;
    logic [3:0]  id;
    logic        per;
    logic [31:0] dur;
    logic [63:0] now;
    bit          typed;
    timer_res_t  want;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [103:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  sorted_timer_queue dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // queue model state
  logic [3:0]  q_order [SLOTS];
  int unsigned q_count;
  logic [63:0] t_expiry [SLOTS];
  logic [31:0] t_period [SLOTS];
  bit          t_periodic [SLOTS];
  bit          t_queued [SLOTS];
  logic [31:0] min_period;

  timer_res_t pending_res [$];
  int errors = 0;
  int results_seen = 0;
  int fired_seen = 0;
  int idle_mode = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic void unlink_timer(int id);
    int p;
    for (p = 0; p < q_count; p++) begin
      if (q_order[p] == id) begin
        for (int q = p; q + 1 < q_count; q++) q_order[q] = q_order[q + 1];
        q_count--;
        break;
      end
    end
    t_queued[id] = 0;
  endfunction

  // returns the insert position
  function automatic int schedule_timer(int id, logic [63:0] now);
    logic [63:0] e;
    int p;
    if (t_periodic[id]) begin
      e = t_expiry[id];
      if (e == 0) begin
        e = now;
        for (int k = 0; k < q_count; k++) begin
          if (t_periodic[q_order[k]] && t_period[q_order[k]] == t_period[id]) begin
            e = t_expiry[q_order[k]];
            break;
          end
        end
      end
      e = e + t_period[id];
    end else begin
      e = now + t_period[id];
    end
    t_expiry[id] = e;
    for (p = 0; p < q_count; p++)
      if (t_expiry[q_order[p]] > e) break;
    for (int q = q_count; q > p; q--) q_order[q] = q_order[q - 1];
    q_order[p] = 4'(id);
    q_count++;
    t_queued[id] = 1;
    return p;
  endfunction

  function automatic void expect_res(logic [1:0] kind, logic [3:0] fid, logic [63:0] cmp,
                                     logic last);
    timer_res_t r;
    r.kind = kind; r.fid = fid; r.cmp = cmp; r.last = last;
    pending_res.push_back(r);
  endfunction

  // work out the results one command causes and update the queue model
  function automatic void predict_timer_cmd(logic [1:0] func, logic [3:0] id, logic per,
                                            logic [31:0] dur, logic [63:0] now);
    int fired;
    int h;
    int p;
    if (func == FUNC_TICK) begin
      fired = 0;
      forever begin
        if (q_count == 0) begin
          expect_res(KIND_NONE, 4'd0, 64'd0, 1'b1);
          return;
        end
        h = q_order[0];
        if (t_expiry[h] > now) begin
          expect_res(KIND_COMPARE, 4'd0, t_expiry[h], 1'b1);
          return;
        end
        if (fired >= FIRE_LIMIT) begin
          expect_res(KIND_COMPARE, 4'd0, now, 1'b1);
          return;
        end
        unlink_timer(h);
        expect_res(KIND_FIRED, 4'(h), 64'd0, 1'b0);
        fired++;
        if (t_periodic[h]) void'(schedule_timer(h, now));
      end
    end else if (func == FUNC_DELETE) begin
      if (t_queued[id]) begin
        p = 0;
        while (q_order[p] != id) p++;
        unlink_timer(id);
        if (p == 0 && q_count > 0) begin
          expect_res(KIND_COMPARE, 4'd0, t_expiry[q_order[0]], 1'b1);
          return;
        end
      end
      expect_res(KIND_NONE, 4'd0, 64'd0, 1'b1);
    end else if (func == FUNC_ADD) begin
      if (per && dur < min_period) begin
        expect_res(KIND_SHORT, 4'd0, 64'd0, 1'b1);
        return;
      end
      if (t_queued[id]) unlink_timer(id);
      t_periodic[id] = per;
      t_period[id] = (!per && dur == 0) ? 32'd1 : dur;
      if (schedule_timer(id, now) == 0) expect_res(KIND_COMPARE, 4'd0, t_expiry[id], 1'b1);
      else expect_res(KIND_NONE, 4'd0, 64'd0, 1'b1);
    end else begin
      expect_res(KIND_NONE, 4'd0, 64'd0, 1'b1);
    end
  endfunction

  // result side: check every accepted item, stall as the idle mode says
  always @(posedge clk) begin
    timer_res_t w;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser == KIND_FIRED) fired_seen++;
      if (pending_res.size() == 0) begin
        errors++;
        $display("unexpected result kind %0d at %0t", m_tuser, $realtime);
      end else begin
        w = pending_res.pop_front();
        if (m_tuser !== w.kind) report_mismatch("kind", m_tuser, w.kind);
        if (m_tdata[3:0] !== w.fid) report_mismatch("fired_id", m_tdata[3:0], w.fid);
        if (m_tdata[67:4] !== w.cmp) report_mismatch("compare_time", m_tdata[67:4], w.cmp);
        if (m_tlast !== w.last) report_mismatch("last", m_tlast, w.last);
      end
    end
    case (idle_mode)
      2: m_tready <= ($urandom_range(99) >= 53);
      3: m_tready <= ($urandom_range(99) >= 25);
      default: m_tready <= 1'b1;
    endcase
  end

  // send one command; valid stays high when no gap follows
  task automatic send_cmd(logic [1:0] func, logic [3:0] id, logic per, logic [31:0] dur,
                          logic [63:0] now);
    int pct;
    pct = (idle_mode == 1) ? 53 : (idle_mode == 3) ? 25 : 0;
    if ($urandom_range(99) < pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {3'b0, now, dur, per, id};
    do @(posedge clk); while (!s_tready);
    predict_timer_cmd(func, id, per, dur, now);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (pending_res.size() != 0) begin
      @(posedge clk);
      waited++;
      if (waited > 200000) begin
        $display("tb_sorted_timer_queue: done, errors");
        $finish;
      end
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic write_min_period(logic [31:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    min_period = v;
  endtask

  cmd_row_t dir_rows [$];
  logic [63:0] tick_now;

  function automatic void add_row(logic [1:0] func, logic [3:0] id, logic per,
                                  logic [31:0] dur, logic [63:0] now, bit typed = 0,
                                  logic [1:0] kind = KIND_NONE, logic [63:0] cmp = 0);
    cmd_row_t r;
    r.func = func; r.id = id; r.per = per; r.dur = dur; r.now = now; r.typed = typed;
    r.want.kind = kind; r.want.fid = 0; r.want.cmp = cmp; r.want.last = 1;
    dir_rows.push_back(r);
  endfunction

  initial begin
    logic [31:0] phase_min [5];
    logic [31:0] span;
    logic [1:0]  f;
    logic [31:0] d;
    logic [63:0] n;
    int r;

    q_count = 0;
    min_period = MIN_PERIOD_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      q_order[i] = 0; t_expiry[i] = 0; t_period[i] = 0; t_periodic[i] = 0; t_queued[i] = 0;
    end

    // directed table: extremes, every operation, ties, wraps, fired limit
    add_row(FUNC_TICK, 0, 0, 0, 64'd0, 1, KIND_NONE, 0);
    add_row(FUNC_ADD, 2, 1, 32'd5, 64'd0, 1, KIND_SHORT, 0);
    add_row(FUNC_ADD, 3, 0, 32'd0, 64'd0, 1, KIND_COMPARE, 64'd1);
    add_row(FUNC_DELETE, 7, 0, 0, 64'd0, 1, KIND_NONE, 0);
    add_row(2'd3, 15, 1, '1, '1, 1, KIND_NONE, 0);
    add_row(FUNC_ADD, 0, 1, 32'd100000, 64'd10);
    add_row(FUNC_ADD, 1, 1, 32'd100000, 64'd50);
    add_row(FUNC_ADD, 15, 0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_row(FUNC_ADD, 8, 0, 32'd5, 64'd2);
    add_row(FUNC_ADD, 9, 0, 32'd5, 64'd2);
    add_row(FUNC_ADD, 8, 0, 32'd100, 64'd2);
    add_row(FUNC_ADD, 4, 1, 32'hFFFF_FFFF, 64'd0);
    add_row(FUNC_DELETE, 3, 0, 0, 64'd3);
    add_row(FUNC_TICK, 0, 0, 0, 64'd7);
    add_row(FUNC_DELETE, 9, 0, 0, 64'd8);
    add_row(FUNC_TICK, 0, 0, 0, 64'd300000);
    add_row(FUNC_ADD, 12, 0, 32'h8000_0000, 64'h8000_0000_0000_0000);
    add_row(FUNC_TICK, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_row(FUNC_TICK, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].func, dir_rows[i].id, dir_rows[i].per, dir_rows[i].dur,
               dir_rows[i].now);
      if (dir_rows[i].typed) begin
        void'(pending_res.pop_back());
        pending_res.push_back(dir_rows[i].want);
      end
    end

    // random phases over several minimum periods, zero and all-ones included
    phase_min[0] = 32'd0;
    phase_min[1] = 32'hFFFF_FFFF;
    phase_min[2] = 32'd1;
    phase_min[3] = $urandom_range(1000, 2);
    phase_min[4] = MIN_PERIOD_RESET;
    tick_now = 64'd400000;
    for (int ph = 0; ph < 5; ph++) begin
      write_min_period(phase_min[ph]);
      span = (phase_min[ph] == 0 || phase_min[ph] == 1) ? 32'd8 :
             (phase_min[ph] > 32'd100000) ? 32'd100000 : phase_min[ph];
      for (int k = 0; k < 44; k++) begin
        idle_mode = (k / 11 + ph) % 4;
        r = $urandom_range(99);
        f = (r < 45) ? FUNC_ADD : (r < 60) ? FUNC_DELETE : (r < 95) ? FUNC_TICK : 2'd3;
        r = $urandom_range(99);
        d = (r < 10) ? $urandom() : (r < 20) ? 32'hFFFF_FFFF : $urandom_range(span * 3);
        if (f == FUNC_TICK) tick_now = tick_now + $urandom_range(span * 2);
        n = ($urandom_range(19) == 0) ? {$urandom(), $urandom()} : tick_now;
        send_cmd(f, 4'($urandom_range(15)), 1'($urandom_range(1)), d, n);
      end
    end

    idle_mode = 0;
    drain_results();
    $display("ran %0d directed and 220 random commands over 5 minimum periods", dir_rows.size());
    $display("checked %0d results, %0d of them fired timers", results_seen, fired_seen);
    if (errors == 0) begin
      $display("tb_sorted_timer_queue: done, clean");
    end else begin
      $display("tb_sorted_timer_queue: done, errors");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20ms;
    $display("tb_sorted_timer_queue: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
design/stq_pkg.sv
design/stq_cell.sv
design/sorted_timer_queue.sv
dv/tb_sorted_timer_queue.sv
